>>> design/idf_pkg.sv
// Package for the in-loop deblocking filter: transaction types and the
// per-line edge test and correction functions. No dependencies.
package idf_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned LineW = 8 * PixW;
  localparam int unsigned QuantW = 5;

  // Input transaction as held in the input register
  typedef struct packed {
    logic [LineW-1:0]  line_a;
    logic [LineW-1:0]  line_b;
    logic [LineW-1:0]  line_c;
    logic [LineW-1:0]  line_d;
    logic [QuantW-1:0] quantizer;
    logic              last_group;
  } in_item_t;

  // Result transaction as held in the output register
  typedef struct packed {
    logic [LineW-1:0] out_a;
    logic [LineW-1:0] out_b;
    logic [LineW-1:0] out_c;
    logic [LineW-1:0] out_d;
    logic             group_active;
    logic             last_out;
  } out_item_t;

  typedef struct packed {
    logic [PixW-1:0] mag;  // |floor(raw / 8)|
    logic            neg;  // raw below zero
  } activity_t;

  typedef struct packed {
    logic [LineW-1:0] line;
    logic             active;
  } line_res_t;

  // |floor((2*(xa-xd) - 5*(xb-xc) + 4) / 8)|; raw fits in 12 signed bits
  function automatic activity_t edge_activity(input logic [PixW-1:0] xa,
                                              input logic [PixW-1:0] xb,
                                              input logic [PixW-1:0] xc,
                                              input logic [PixW-1:0] xd);
    logic signed [11:0] dad;
    logic signed [11:0] dbc;
    logic signed [11:0] raw;
    logic signed [11:0] flr;
    logic signed [11:0] mag;
    activity_t          res;
    dad = $signed({4'b0, xa}) - $signed({4'b0, xd});
    dbc = $signed({4'b0, xb}) - $signed({4'b0, xc});
    raw = (dad <<< 1) - (dbc <<< 2) - dbc + 12'sd4;
    flr = raw >>> 3;
    mag = flr[11] ? -flr : flr;
    res.mag = mag[PixW-1:0];
    res.neg = raw[11];
    return res;
  endfunction

  function automatic logic [PixW-1:0] clamp_pix(input logic signed [9:0] v);
    logic [PixW-1:0] r;
    if (v[9]) begin
      r = '0;
    end else if (v[8]) begin
      r = '1;
    end else begin
      r = v[PixW-1:0];
    end
    return r;
  endfunction

  // Test one line and, when active and the direction agrees, move P1 and Q1 toward each other
  function automatic line_res_t filter_line(input logic [LineW-1:0]  line,
                                            input logic [QuantW-1:0] q);
    logic [PixW-1:0]    x [8];
    activity_t          a0;
    activity_t          a1;
    activity_t          a2;
    logic [PixW-1:0]    a3;
    logic signed [8:0]  diff;
    logic [PixW-1:0]    absd;
    logic [PixW-2:0]    c;
    logic [PixW-1:0]    sub;
    logic [10:0]        prod;
    logic [PixW-1:0]    m;
    logic [PixW-1:0]    d;
    logic signed [9:0]  p1;
    logic signed [9:0]  q1;
    logic               act;
    line_res_t          res;
    for (int k = 0; k < 8; k++) begin
      x[k] = line[k*PixW +: PixW];
    end
    a0   = edge_activity(x[2], x[3], x[4], x[5]);
    a1   = edge_activity(x[0], x[1], x[2], x[3]);
    a2   = edge_activity(x[4], x[5], x[6], x[7]);
    a3   = (a1.mag < a2.mag) ? a1.mag : a2.mag;
    diff = $signed({1'b0, x[3]}) - $signed({1'b0, x[4]});
    absd = diff[8] ? PixW'(-diff) : diff[PixW-1:0];
    c    = absd[PixW-1:1];
    act  = (a0.mag < {3'b0, q}) && (a3 < a0.mag) && (c != '0);
    sub  = a0.mag - a3;
    prod = {1'b0, sub, 2'b0} + {3'b0, sub};
    m    = prod[10:3];
    d    = (m > {1'b0, c}) ? {1'b0, c} : m;
    // x3 < x4 pulls P1 up and Q1 down, otherwise the reverse
    if (diff[8]) begin
      p1 = $signed({2'b0, x[3]}) + $signed({2'b0, d});
      q1 = $signed({2'b0, x[4]}) - $signed({2'b0, d});
    end else begin
      p1 = $signed({2'b0, x[3]}) - $signed({2'b0, d});
      q1 = $signed({2'b0, x[4]}) + $signed({2'b0, d});
    end
    res.line   = line;
    res.active = act;
    // correction only where its direction (opposite to a0's sign) matches x3-x4
    if (act && (a0.neg != diff[8])) begin
      res.line[3*PixW +: PixW] = clamp_pix(p1);
      res.line[4*PixW +: PixW] = clamp_pix(q1);
    end
    return res;
  endfunction

endpackage

>>> design/idf_in_if.sv
// Input channel of the deblocking filter: valid/ready plus one segment.
// Depends on idf_pkg for widths.
interface idf_in_if
  import idf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [LineW-1:0]  line_a;
  logic [LineW-1:0]  line_b;
  logic [LineW-1:0]  line_c;
  logic [LineW-1:0]  line_d;
  logic [QuantW-1:0] quantizer;
  logic              last_group;

  modport source (output valid, line_a, line_b, line_c, line_d, quantizer,
                  last_group, input ready);
  modport sink   (input valid, line_a, line_b, line_c, line_d, quantizer,
                  last_group, output ready);
endinterface

>>> design/idf_out_if.sv
// Output channel of the deblocking filter: valid/ready plus filtered lines.
// Depends on idf_pkg for widths.
interface idf_out_if
  import idf_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [LineW-1:0] out_a;
  logic [LineW-1:0] out_b;
  logic [LineW-1:0] out_c;
  logic [LineW-1:0] out_d;
  logic             group_active;
  logic             last_out;

  modport source (output valid, out_a, out_b, out_c, out_d, group_active,
                  last_out, input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_d, group_active,
                  last_out, output ready);
endinterface

>>> design/inloop_deblock_filter_top.sv
// In-loop deblocking filter top: input register, per-line filter logic, result register.
// Depends on idf_pkg, idf_in_if and idf_out_if.
// Throughput: one transaction per cycle while the sink takes results; set by the
// single filter pass between the input and result registers, with no state carried
// between segments.
// Reset (rst_ni low, async) empties both register stages; payload is not reset.
module inloop_deblock_filter_top
  import idf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  idf_in_if.sink    in_i,
  idf_out_if.source out_o
);

  // Stage 1: captured input transaction
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_q;
  // Stage 2: finished result waiting for the sink
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic in_fire;
  logic s1_adv;   // stage 1 moves into the result register

  // The result register frees up when empty or when the sink takes it;
  // stage 1 takes a new transaction when empty or when its content can move on.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Filter pass: the third line decides whether the other three are touched
  line_res_t res_a, res_b, res_c, res_d;

  always_comb begin
    res_a = filter_line(s1_q.line_a, s1_q.quantizer);
    res_b = filter_line(s1_q.line_b, s1_q.quantizer);
    res_c = filter_line(s1_q.line_c, s1_q.quantizer);
    res_d = filter_line(s1_q.line_d, s1_q.quantizer);
    out_d.out_c        = res_c.line;
    out_d.out_a        = res_c.active ? res_a.line : s1_q.line_a;
    out_d.out_b        = res_c.active ? res_b.line : s1_q.line_b;
    out_d.out_d        = res_c.active ? res_d.line : s1_q.line_d;
    out_d.group_active = res_c.active;
    out_d.last_out     = s1_q.last_group;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.line_a     <= in_i.line_a;
      s1_q.line_b     <= in_i.line_b;
      s1_q.line_c     <= in_i.line_c;
      s1_q.line_d     <= in_i.line_d;
      s1_q.quantizer  <= in_i.quantizer;
      s1_q.last_group <= in_i.last_group;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_a        = out_q.out_a;
  assign out_o.out_b        = out_q.out_b;
  assign out_o.out_c        = out_q.out_c;
  assign out_o.out_d        = out_q.out_d;
  assign out_o.group_active = out_q.group_active;
  assign out_o.last_out     = out_q.last_out;

endmodule
